// ===== sv/iou_dm_pkg.sv =====
// Shared types and constants for the IoU detection matcher.
package iou_dm_pkg;

  localparam int unsigned MAX_BOXES = 16;
  localparam int unsigned IDX_W     = $clog2(MAX_BOXES);
  localparam int unsigned CNT_W     = $clog2(MAX_BOXES + 1);
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned AREA_W    = 2 * COORD_W;
  localparam int unsigned FP_W      = 16;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TEST  = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_CORRECT  = 3'd0,
    KIND_FALSE    = 3'd1,
    KIND_DUP      = 3'd2,
    KIND_MISSED   = 3'd3,
    KIND_SUMMARY  = 3'd4,
    KIND_REJECTED = 3'd5
  } kind_e;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
  } box_t;

endpackage

// ===== sv/iou_detection_matcher.sv =====
// IoU detection matcher: truth table, shared multiplier and scan sequencer.
//
// Truth boxes are loaded one per item into a 16-entry table; a load computes
// the truth area on the shared 16x16 multiplier and stores it, and a load
// into a full table echoes the box back. A detection first takes its own
// area on the multiplier, then scans the loaded entries up to and including
// the first hit (all loaded entries when nothing hits): each entry needs an
// overlap step, a multiply on the shared multiplier and a compare of 3*inter
// against the sum of the areas. A flush walks the n loaded entries, emitting
// each unmatched one as missed, then a summary; it waits while the output is
// stalled. The block takes no item while it works on one; the last result
// sits in an output register, so the next item is accepted while it waits.
module iou_detection_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] box_left_i,
  input  logic [15:0] box_top_i,
  input  logic [15:0] box_width_i,
  input  logic [15:0] box_height_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [15:0] out_left_o,
  output logic [15:0] out_top_o,
  output logic [15:0] out_width_o,
  output logic [15:0] out_height_o,
  output logic [4:0]  correct_count_o,
  output logic [15:0] false_pos_count_o,
  output logic [4:0]  missed_count_o,
  output logic [4:0]  truth_count_o,
  output logic        last_o
);

  localparam int unsigned IW = iou_dm_pkg::IDX_W;
  localparam int unsigned CW = iou_dm_pkg::CNT_W;
  localparam int unsigned XW = iou_dm_pkg::COORD_W;
  localparam int unsigned AW = iou_dm_pkg::AREA_W;
  localparam int unsigned FW = iou_dm_pkg::FP_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_AREA,
    ST_DET_AREA,
    ST_OVL,
    ST_MUL,
    ST_CMP,
    ST_EMIT,
    ST_FLUSH,
    ST_SUMMARY
  } state_e;

  state_e                state_q;
  iou_dm_pkg::box_t      det_q;
  iou_dm_pkg::box_t      truth_mem [iou_dm_pkg::MAX_BOXES];
  logic [AW-1:0]         area_mem  [iou_dm_pkg::MAX_BOXES];
  logic [iou_dm_pkg::MAX_BOXES-1:0] matched_q;
  logic [CW-1:0]         entries_q;
  logic [CW-1:0]         correct_q;
  logic [FW-1:0]         fp_q;
  logic [CW-1:0]         missed_q;
  logic [CW-1:0]         idx_q;
  logic [AW-1:0]         det_area_q;
  logic [AW:0]           sum_q;
  logic [XW-1:0]         ov_w_q;
  logic [XW-1:0]         ov_h_q;
  logic [AW-1:0]         inter_q;
  iou_dm_pkg::kind_e     kind_q;

  logic                  out_valid_q;
  logic                  out_valid_d;
  iou_dm_pkg::kind_e     out_kind_q;
  iou_dm_pkg::box_t      out_box_q;
  logic [CW-1:0]         out_cc_q;
  logic [FW-1:0]         out_fp_q;
  logic [CW-1:0]         out_mc_q;
  logic [CW-1:0]         out_tc_q;
  logic                  out_last_q;

  logic [XW-1:0]         mul_a;
  logic [XW-1:0]         mul_b;
  logic [AW-1:0]         mul_p;
  logic [IW-1:0]         idx;
  logic [AW+1:0]         tri_inter;
  logic                  hit;
  logic                  slot_free;
  logic                  in_acc;
  logic                  scan_end;

  function automatic logic [XW-1:0] overlap(input logic [XW-1:0] a0, input logic [XW-1:0] al,
                                            input logic [XW-1:0] b0, input logic [XW-1:0] bl);
    logic [XW:0] lo;
    logic [XW:0] ae;
    logic [XW:0] be;
    logic [XW:0] hi;
    logic [XW:0] diff;
    lo   = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    ae   = {1'b0, a0} + {1'b0, al};
    be   = {1'b0, b0} + {1'b0, bl};
    hi   = (ae < be) ? ae : be;
    diff = hi - lo;
    return (hi > lo) ? diff[XW-1:0] : '0;
  endfunction

  assign idx       = idx_q[IW-1:0];
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign scan_end  = (CW'(idx_q + 1'b1) == entries_q);

  // shared multiplier
  always_comb begin
    if (state_q == ST_MUL) begin
      mul_a = ov_w_q;
      mul_b = ov_h_q;
    end else begin
      mul_a = det_q.width;
      mul_b = det_q.height;
    end
  end
  assign mul_p = AW'(mul_a) * AW'(mul_b);

  assign tri_inter = {2'b00, inter_q} + {1'b0, inter_q, 1'b0};
  assign hit       = tri_inter > {1'b0, sum_q};

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_EMIT, ST_SUMMARY: begin
        if (slot_free) out_valid_d = 1'b1;
      end
      ST_FLUSH: begin
        if (slot_free && (idx_q < entries_q) && !matched_q[idx]) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // truth table storage
  always_ff @(posedge clk_i) begin
    if (in_acc && (operation_i == iou_dm_pkg::OP_LOAD) &&
        (entries_q < CW'(iou_dm_pkg::MAX_BOXES))) begin
      truth_mem[entries_q[IW-1:0]] <= {box_left_i, box_top_i, box_width_i, box_height_i};
    end
    if (state_q == ST_LOAD_AREA) begin
      area_mem[entries_q[IW-1:0]] <= mul_p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      det_q       <= '0;
      matched_q   <= '0;
      entries_q   <= '0;
      correct_q   <= '0;
      fp_q        <= '0;
      missed_q    <= '0;
      idx_q       <= '0;
      det_area_q  <= '0;
      sum_q       <= '0;
      ov_w_q      <= '0;
      ov_h_q      <= '0;
      inter_q     <= '0;
      kind_q      <= iou_dm_pkg::KIND_FALSE;
      out_valid_q <= 1'b0;
      out_kind_q  <= iou_dm_pkg::KIND_FALSE;
      out_box_q   <= '0;
      out_cc_q    <= '0;
      out_fp_q    <= '0;
      out_mc_q    <= '0;
      out_tc_q    <= '0;
      out_last_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            det_q    <= {box_left_i, box_top_i, box_width_i, box_height_i};
            idx_q    <= '0;
            missed_q <= '0;
            case (operation_i)
              iou_dm_pkg::OP_LOAD: begin
                if (entries_q < CW'(iou_dm_pkg::MAX_BOXES)) begin
                  matched_q[entries_q[IW-1:0]] <= 1'b0;
                  state_q <= ST_LOAD_AREA;
                end else begin
                  kind_q  <= iou_dm_pkg::KIND_REJECTED;
                  state_q <= ST_EMIT;
                end
              end
              iou_dm_pkg::OP_TEST:  state_q <= ST_DET_AREA;
              iou_dm_pkg::OP_FLUSH: state_q <= ST_FLUSH;
              default:              state_q <= ST_IDLE;
            endcase
          end
        end
        ST_LOAD_AREA: begin
          entries_q <= CW'(entries_q + 1'b1);
          state_q   <= ST_IDLE;
        end
        ST_DET_AREA: begin
          det_area_q <= mul_p;
          if (entries_q == '0) begin
            kind_q <= iou_dm_pkg::KIND_FALSE;
            if (fp_q != '1) fp_q <= FW'(fp_q + 1'b1);
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_OVL;
          end
        end
        ST_OVL: begin
          ov_w_q  <= overlap(truth_mem[idx].left, truth_mem[idx].width,
                             det_q.left, det_q.width);
          ov_h_q  <= overlap(truth_mem[idx].top, truth_mem[idx].height,
                             det_q.top, det_q.height);
          sum_q   <= {1'b0, area_mem[idx]} + {1'b0, det_area_q};
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          inter_q <= mul_p;
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (hit) begin
            if (matched_q[idx]) begin
              kind_q <= iou_dm_pkg::KIND_DUP;
            end else begin
              kind_q         <= iou_dm_pkg::KIND_CORRECT;
              matched_q[idx] <= 1'b1;
              correct_q      <= CW'(correct_q + 1'b1);
            end
            state_q <= ST_EMIT;
          end else if (scan_end) begin
            kind_q <= iou_dm_pkg::KIND_FALSE;
            if (fp_q != '1) fp_q <= FW'(fp_q + 1'b1);
            state_q <= ST_EMIT;
          end else begin
            idx_q   <= CW'(idx_q + 1'b1);
            state_q <= ST_OVL;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_kind_q  <= kind_q;
            out_box_q   <= det_q;
            out_cc_q    <= '0;
            out_fp_q    <= '0;
            out_mc_q    <= '0;
            out_tc_q    <= '0;
            out_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_FLUSH: begin
          if (idx_q >= entries_q) begin
            state_q <= ST_SUMMARY;
          end else if (matched_q[idx]) begin
            idx_q <= CW'(idx_q + 1'b1);
          end else if (slot_free) begin
            out_kind_q  <= iou_dm_pkg::KIND_MISSED;
            out_box_q   <= truth_mem[idx];
            out_cc_q    <= '0;
            out_fp_q    <= '0;
            out_mc_q    <= '0;
            out_tc_q    <= '0;
            out_last_q  <= 1'b0;
            missed_q    <= CW'(missed_q + 1'b1);
            idx_q       <= CW'(idx_q + 1'b1);
          end
        end
        ST_SUMMARY: begin
          if (slot_free) begin
            out_kind_q  <= iou_dm_pkg::KIND_SUMMARY;
            out_box_q   <= '0;
            out_cc_q    <= correct_q;
            out_fp_q    <= fp_q;
            out_mc_q    <= missed_q;
            out_tc_q    <= entries_q;
            out_last_q  <= 1'b1;
            matched_q   <= '0;
            entries_q   <= '0;
            correct_q   <= '0;
            fp_q        <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_kind_q;
  assign out_left_o        = out_box_q.left;
  assign out_top_o         = out_box_q.top;
  assign out_width_o       = out_box_q.width;
  assign out_height_o      = out_box_q.height;
  assign correct_count_o   = out_cc_q;
  assign false_pos_count_o = out_fp_q;
  assign missed_count_o    = out_mc_q;
  assign truth_count_o     = out_tc_q;
  assign last_o            = out_last_q;

  a_entries_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entries_q <= CW'(iou_dm_pkg::MAX_BOXES))
    else $error("truth table count exceeds capacity");

  a_correct_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    correct_q <= entries_q)
    else $error("more correct matches than loaded entries");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == iou_dm_pkg::KIND_SUMMARY)) |-> out_last_q)
    else $error("summary item without last");

  a_missed_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == iou_dm_pkg::KIND_MISSED)) |-> !out_last_q)
    else $error("missed item flagged last");

endmodule
